// ----- rtl/core/qrs_pkg.sv -----
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared types and constants for the QR module raster scaler.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int VER_W    = 5;
	localparam int NUM_W    = 8;   // module count per side, up to 4*31+17
	localparam int MOD_W    = 9;   // module row/column index after extension
	localparam int WORD_W   = 64;
	localparam int ROW_W    = 7;
	localparam int ADDR_W   = 8;
	localparam int DEPTH    = 256;
	localparam int MOD_BASE = 17;

	localparam logic [VER_W-1:0] VER_RESET = 5'd3;
	localparam logic [7:0]       LIGHT_BYTE = 8'hFF;
	localparam logic [7:0]       DARK_BYTE  = 8'h00;
	localparam logic [1:0]       LAST_CHAN  = 2'd2;
	localparam logic             CMD_LOAD   = 1'b0;
	localparam logic             CMD_PIXEL  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GSTART,
		ST_GDIV,
		ST_GLEAD,
		ST_CDIV,
		ST_RDIV,
		ST_READ,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		SEL_GEOM,
		SEL_COL,
		SEL_ROW
	} div_sel_t;

endpackage

// ----- rtl/core/qrs_in_if.sv -----
// ----------------------------------------------------------------------------
// qrs_in_if
// Input channel: load and pixel commands with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qrs_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [6:0]  module_row;
	logic        module_word;
	logic [63:0] module_bits;

	modport source (output valid, cmd, module_row, module_word, module_bits, input ready);
	modport sink   (input valid, cmd, module_row, module_word, module_bits, output ready);
endinterface

// ----- rtl/core/qrs_out_if.sv -----
// ----------------------------------------------------------------------------
// qrs_out_if
// Output channel: one colour byte per beat with valid/ready handshake.
// ----------------------------------------------------------------------------
interface qrs_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] colour_byte;
	logic [1:0] colour_channel;
	logic       pixel_done;
	logic       frame_end;

	modport source (output valid, colour_byte, colour_channel, pixel_done, frame_end,
		input ready);
	modport sink   (input valid, colour_byte, colour_channel, pixel_done, frame_end,
		output ready);
endinterface

// ----- rtl/core/qrs_div.sv -----
// ----------------------------------------------------------------------------
// qrs_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qrs_div import qrs_pkg::*; #(
	parameter int DW = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DW-1:0]     dividend,
	input  logic [NUM_W-1:0]  divisor,
	output logic              done,
	output logic [DW-1:0]     quotient
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [NUM_W-1:0] rem_q;
	logic [DW-1:0]    quo_q;
	logic [NUM_W+1:0] diff;
	logic             neg;

	assign diff = {1'b0, rem_q, quo_q[DW-1]} - {2'b00, divisor};
	assign neg  = diff[NUM_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= CNT_W'(DW);
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - 1'b1;
				done_q <= (cnt_q == CNT_W'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (cnt_q != '0) begin
			rem_q <= neg ? {rem_q[NUM_W-2:0], quo_q[DW-1]} : diff[NUM_W-1:0];
			quo_q <= {quo_q[DW-2:0], ~neg};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- rtl/core/qrs_store.sv -----
// ----------------------------------------------------------------------------
// qrs_store
// Module bitmap store, 256 words of 64 bits, registered read.
// ----------------------------------------------------------------------------
module qrs_store import qrs_pkg::*; (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WORD_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem [DEPTH];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/qr_module_raster_scaler.sv -----
// ----------------------------------------------------------------------------
// qr_module_raster_scaler
// Scales a stored QR module bitmap to a square display raster, three colour
// bytes per pixel, with quiet zone around the code.
// ----------------------------------------------------------------------------
// Load beat: written to the store when accepted. Quiet-zone pixel: no division, then three output beats.
// Module pixel: two divisions on the shared divider, each of DW = clog2(DISPLAY_SIDE+1)
// quotient bits, plus a store read, then three output beats.
// Version write: geometry recomputed on the same divider, not ready from the write
// cycle until the geometry is done.
// Reset: version 3 with its geometry, pixel counter at the frame start.
// ----------------------------------------------------------------------------
module qr_module_raster_scaler import qrs_pkg::*; #(
	parameter int DISPLAY_SIDE = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VER_W-1:0] cfg_wdata,
	qrs_in_if.sink           req,
	qrs_out_if.source        rsp
);

	localparam int CW = $clog2(DISPLAY_SIDE);
	localparam int DW = $clog2(DISPLAY_SIDE + 1);
	localparam int RST_MODS  = 4 * int'(VER_RESET) + MOD_BASE;
	localparam int RST_SCALE = DISPLAY_SIDE / RST_MODS;
	localparam int RST_USED  = RST_MODS * RST_SCALE;
	localparam int RST_LEAD  = (DISPLAY_SIDE - RST_USED) / 2;
	localparam int RST_END   = RST_LEAD + RST_USED;
	localparam logic [CW-1:0] LAST_POS = CW'(DISPLAY_SIDE - 1);

	state_t            state_q, state_n;
	div_sel_t          div_sel;
	logic              div_start;
	logic              div_done;
	logic [DW-1:0]     div_quo;
	logic [DW-1:0]     div_dividend;
	logic [NUM_W-1:0]  div_divisor;

	logic [VER_W-1:0]  version_q;
	logic [DW-1:0]     scale_q, lead_q, end_q;
	logic [CW-1:0]     pcol_q, prow_q;
	logic [DW-1:0]     row_off_q;
	logic [MOD_W-1:0]  mcol_q, mrow_q;
	logic              quiet_q, last_q;
	logic [1:0]        chan_q;

	logic [NUM_W-1:0]  mods;
	logic [NUM_W+DW-1:0] prod;
	logic [DW-1:0]     used;
	logic [DW-1:0]     pc_ext, pr_ext, col_off, row_off;
	logic              quiet, last_pix;
	logic              accept, pix_accept, load_accept, beat;
	logic [WORD_W-1:0] rdata;
	logic              dark;

	assign mods    = {1'b0, version_q, 2'b00} + NUM_W'(MOD_BASE);
	assign prod    = mods * scale_q;
	assign used    = prod[DW-1:0];

	assign pc_ext  = DW'(pcol_q);
	assign pr_ext  = DW'(prow_q);
	assign col_off = pc_ext - lead_q;
	assign row_off = pr_ext - lead_q;
	assign quiet   = (pc_ext < lead_q) || (pc_ext >= end_q) ||
	                 (pr_ext < lead_q) || (pr_ext >= end_q);
	assign last_pix = (pcol_q == LAST_POS) && (prow_q == LAST_POS);

	assign accept      = req.valid && req.ready;
	assign pix_accept  = accept && (req.cmd == CMD_PIXEL);
	assign load_accept = accept && (req.cmd == CMD_LOAD);
	assign beat        = rsp.valid && rsp.ready;

	always_comb begin
		case (div_sel)
			SEL_GEOM: begin
				div_dividend = DW'(DISPLAY_SIDE);
				div_divisor  = mods;
			end
			SEL_COL: begin
				div_dividend = col_off;
				div_divisor  = NUM_W'(scale_q);
			end
			SEL_ROW: begin
				div_dividend = row_off_q;
				div_divisor  = NUM_W'(scale_q);
			end
			default: begin
				div_dividend = DW'(DISPLAY_SIDE);
				div_divisor  = mods;
			end
		endcase
	end

	qrs_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	qrs_store u_store (
		.clk   (clk),
		.we    (load_accept),
		.waddr ({req.module_row, req.module_word}),
		.wdata (req.module_bits),
		.raddr ({mrow_q[ROW_W-1:0], mcol_q[6]}),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n   = state_q;
		req.ready = 1'b0;
		rsp.valid = 1'b0;
		div_start = 1'b0;
		div_sel   = SEL_GEOM;
		case (state_q)
			ST_IDLE: begin
				req.ready = !cfg_we;
				if (cfg_we) begin
					state_n = ST_GSTART;
				end else if (req.valid && req.cmd == CMD_PIXEL) begin
					if (quiet) begin
						state_n = ST_EMIT;
					end else begin
						div_start = 1'b1;
						div_sel   = SEL_COL;
						state_n   = ST_CDIV;
					end
				end
			end
			ST_GSTART: begin
				div_start = 1'b1;
				state_n   = ST_GDIV;
			end
			ST_GDIV: begin
				if (div_done) begin
					state_n = ST_GLEAD;
				end
			end
			ST_GLEAD: begin
				state_n = ST_IDLE;
			end
			ST_CDIV: begin
				div_sel = SEL_COL;
				if (div_done) begin
					div_start = 1'b1;
					div_sel   = SEL_ROW;
					state_n   = ST_RDIV;
				end
			end
			ST_RDIV: begin
				div_sel = SEL_ROW;
				if (div_done) begin
					state_n = ST_READ;
				end
			end
			ST_READ: begin
				state_n = ST_EMIT;
			end
			ST_EMIT: begin
				rsp.valid = 1'b1;
				if (rsp.ready && chan_q == LAST_CHAN) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	// geometry and raster position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			version_q <= VER_RESET;
			scale_q   <= DW'(RST_SCALE);
			lead_q    <= DW'(RST_LEAD);
			end_q     <= DW'(RST_END);
			pcol_q    <= '0;
			prow_q    <= '0;
			chan_q    <= '0;
		end else begin
			if (cfg_we) begin
				version_q <= cfg_wdata;
			end
			if (state_q == ST_GDIV && div_done) begin
				scale_q <= div_quo;
			end
			if (state_q == ST_GLEAD) begin
				lead_q <= (DW'(DISPLAY_SIDE) - used) >> 1;
				end_q  <= ((DW'(DISPLAY_SIDE) - used) >> 1) + used;
			end
			if (pix_accept) begin
				if (pcol_q == LAST_POS) begin
					pcol_q <= '0;
					prow_q <= (prow_q == LAST_POS) ? '0 : prow_q + 1'b1;
				end else begin
					pcol_q <= pcol_q + 1'b1;
				end
			end
			if (beat) begin
				chan_q <= (chan_q == LAST_CHAN) ? '0 : chan_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix_accept) begin
			quiet_q   <= quiet;
			last_q    <= last_pix;
			row_off_q <= row_off;
		end
		if (state_q == ST_CDIV && div_done) begin
			mcol_q <= MOD_W'(div_quo);
		end
		if (state_q == ST_RDIV && div_done) begin
			mrow_q <= MOD_W'(div_quo);
		end
	end

	// columns and rows past the store read as light
	assign dark = !(|mrow_q[MOD_W-1:ROW_W]) && !(|mcol_q[MOD_W-1:ROW_W]) &&
	              rdata[mcol_q[5:0]];

	assign rsp.colour_byte    = (quiet_q || !dark) ? LIGHT_BYTE : DARK_BYTE;
	assign rsp.colour_channel = chan_q;
	assign rsp.pixel_done     = (chan_q == LAST_CHAN);
	assign rsp.frame_end      = last_q;

endmodule

// ----- tb/qr_module_raster_scaler_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_module_raster_scaler_chk
// Watches the command, response and version write ports of the raster
// scaler. It keeps its own module store, geometry and raster position, works
// out the three colour beats of every accepted pixel command and compares
// each response beat with the oldest one still outstanding.
// ----------------------------------------------------------------------------
module qr_module_raster_scaler_chk import qrs_pkg::*; #(
	parameter int DISPLAY_SIDE = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [VER_W-1:0] cfg_wdata,
	qrs_in_if                req,
	qrs_out_if               rsp,
	output int               mismatches,
	output int               pending
);

	localparam int RASTER    = DISPLAY_SIDE * DISPLAY_SIDE;
	localparam int STORE_ROW = 1 << ROW_W;

	typedef struct packed {
		logic [7:0] colour;
		logic [1:0] chan;
		logic       done;
		logic       last;
	} colour_beat_t;

	colour_beat_t      due_beats[$];
	logic [WORD_W-1:0] module_mem [DEPTH];
	int                scale;
	int                lead;
	int                trail;
	int                raster_pos;

	function automatic void set_geometry(input logic [VER_W-1:0] ver);
		int modules;
		int spare;
		modules = 4 * ver + MOD_BASE;
		scale   = DISPLAY_SIDE / modules;
		spare   = DISPLAY_SIDE - modules * scale;
		lead    = spare / 2;
		trail   = spare - lead;
	endfunction

	function automatic logic [7:0] pixel_colour(input int pos);
		int                prow;
		int                pcol;
		int                mrow;
		int                mcol;
		logic [WORD_W-1:0] word;
		prow = pos / DISPLAY_SIDE;
		pcol = pos % DISPLAY_SIDE;
		if (scale == 0 || pcol < lead || pcol >= DISPLAY_SIDE - trail ||
				prow < lead || prow >= DISPLAY_SIDE - trail)
			return LIGHT_BYTE;
		mcol = (pcol - lead) / scale;
		mrow = (prow - lead) / scale;
		if (mrow >= STORE_ROW || mcol >= STORE_ROW)
			return LIGHT_BYTE;
		word = module_mem[mrow * 2 + mcol / WORD_W];
		return word[mcol % WORD_W] ? DARK_BYTE : LIGHT_BYTE;
	endfunction

	function automatic void log_failure(input string what, input colour_beat_t want,
			input colour_beat_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected %02h/%0d/%0b/%0b, got %02h/%0d/%0b/%0b",
				$time, what, want.colour, want.chan, want.done, want.last,
				got.colour, got.chan, got.done, got.last);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [7:0]   colour;
		logic         last;
		colour_beat_t got;
		colour_beat_t want;
		if (!arst_n) begin
			due_beats.delete();
			raster_pos = 0;
			mismatches = 0;
			set_geometry(VER_RESET);
		end else begin
			if (cfg_we)
				set_geometry(cfg_wdata);
			if (req.valid && req.ready) begin
				if (req.cmd == CMD_LOAD) begin
					module_mem[{req.module_row, req.module_word}] = req.module_bits;
				end else begin
					colour = pixel_colour(raster_pos);
					last   = (raster_pos == RASTER - 1);
					for (int k = 0; k < 3; k++)
						due_beats.push_back('{colour, 2'(k), (k == LAST_CHAN), last});
					raster_pos = last ? 0 : raster_pos + 1;
				end
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.colour_byte, rsp.colour_channel, rsp.pixel_done, rsp.frame_end};
				if (due_beats.size() == 0) begin
					log_failure("unexpected beat", '0, got);
				end else begin
					want = due_beats.pop_front();
					if (got.colour !== want.colour || got.chan !== want.chan ||
							got.done !== want.done || got.last !== want.last)
						log_failure("beat mismatch", want, got);
				end
			end
		end
		pending = due_beats.size();
	end

endmodule

// ----- tb/qr_module_raster_scaler_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qr_module_raster_scaler_tb
// Drives load and pixel commands and version writes into the raster scaler
// with random gaps on both channels, including all-quiet versions, and
// reports the checker's verdict.
// ----------------------------------------------------------------------------
module qr_module_raster_scaler_tb;
	import qrs_pkg::*;

	localparam int DISPLAY_SIDE = 128;
	localparam int SETTLE       = 40;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [VER_W-1:0] cfg_wdata = '0;
	bit               gaps_on = 1'b1;
	int               mismatches;
	int               pending;

	qrs_in_if  req ();
	qrs_out_if rsp ();

	qr_module_raster_scaler #(.DISPLAY_SIDE(DISPLAY_SIDE)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	qr_module_raster_scaler_chk #(.DISPLAY_SIDE(DISPLAY_SIDE)) u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.req        (req),
		.rsp        (rsp),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#70_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// response side: random hold-off before each beat
	initial begin
		int gap;
		rsp.ready = 1'b0;
		wait (arst_n);
		forever begin
			gap = gaps_on ? $urandom_range(0, 12) : 0;
			@(negedge clk);
			if (gap != 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp.ready <= 1'b1;
			@(posedge clk);
			while (!(rsp.valid && rsp.ready)) @(posedge clk);
		end
	end

	function automatic logic [WORD_W-1:0] rand_bits();
		case ($urandom_range(0, 7))
			0:       return '0;
			1:       return '1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic push_beat(input logic c, input logic [ROW_W-1:0] r, input logic w,
			input logic [WORD_W-1:0] b);
		int gap;
		gap = gaps_on ? $urandom_range(0, 12) : 0;
		@(negedge clk);
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req.valid       <= 1'b1;
		req.cmd         <= c;
		req.module_row  <= r;
		req.module_word <= w;
		req.module_bits <= b;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
	endtask

	task automatic load_word(input logic [ROW_W-1:0] r, input logic w,
			input logic [WORD_W-1:0] b);
		push_beat(CMD_LOAD, r, w, b);
	endtask

	task automatic next_pixel();
		push_beat(CMD_PIXEL, ROW_W'($urandom), 1'($urandom), {$urandom, $urandom});
	endtask

	task automatic drain();
		@(negedge clk);
		req.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_version(input logic [VER_W-1:0] ver);
		drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ver;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int               slots [DEPTH];
		int               j;
		int               tmp;
		int               n;
		int               done_items;
		logic [VER_W-1:0] ver;
		req.valid       = 1'b0;
		req.cmd         = CMD_LOAD;
		req.module_row  = '0;
		req.module_word = 1'b0;
		req.module_bits = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: store extremes, then pixels inside the top quiet rows
		load_word(ROW_W'(0), 1'b0, '1);
		load_word(ROW_W'(0), 1'b1, '0);
		load_word(ROW_W'(127), 1'b1, {32{2'b10}});
		load_word(ROW_W'(127), 1'b0, {32{2'b01}});
		load_word(ROW_W'(64), 1'b0, {$urandom, $urandom});
		repeat (4) next_pixel();
		set_version(VER_W'(0));
		repeat (3) next_pixel();
		set_version(VER_W'(27));
		repeat (3) next_pixel();
		set_version(VER_W'(31));
		repeat (3) next_pixel();

		// fill every store word in random order before the module area is reached
		for (int i = 0; i < DEPTH; i++)
			slots[i] = i;
		for (int i = DEPTH - 1; i > 0; i--) begin
			j        = $urandom_range(0, i);
			tmp      = slots[i];
			slots[i] = slots[j];
			slots[j] = tmp;
		end
		foreach (slots[i])
			load_word(ROW_W'(slots[i] >> 1), slots[i][0], rand_bits());

		done_items = 0;
		while (done_items < 220) begin
			case ($urandom_range(0, 6))
				0:       ver = VER_W'(0);
				1:       ver = VER_W'(1);
				2:       ver = VER_W'(27);
				3:       ver = VER_W'($urandom_range(28, 31));
				default: ver = VER_W'($urandom_range(1, 27));
			endcase
			set_version(ver);
			gaps_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(10, 40);
			repeat (n) begin
				if ($urandom_range(0, 4) == 0)
					load_word(ROW_W'($urandom), 1'($urandom), rand_bits());
				else
					next_pixel();
				done_items++;
			end
		end

		gaps_on = 1'b1;
		drain();
		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/qrs_pkg.sv
rtl/core/qrs_in_if.sv
rtl/core/qrs_out_if.sv
rtl/core/qrs_div.sv
rtl/core/qrs_store.sv
rtl/core/qr_module_raster_scaler.sv
tb/qr_module_raster_scaler_chk.sv
tb/qr_module_raster_scaler_tb.sv
